// ===== hw/rtl/fcsi_pkg.sv =====
// Shared types and constants for the first-character counting sort index engine
`timescale 1ns / 1ps
`default_nettype none

package fcsi_pkg;

  localparam int BINS  = 36;
  localparam int BIN_W = 6;
  localparam int KEY_W = 8;
  localparam int CNT_W = 21;
  localparam int POS_W = 20;

  localparam logic [CNT_W-1:0] MAX_ITEMS = 21'd1048576;

  localparam logic [KEY_W-1:0] KEY_DIGIT_LO = 8'd48;
  localparam logic [KEY_W-1:0] KEY_DIGIT_HI = 8'd57;
  localparam logic [KEY_W-1:0] KEY_ALPHA_LO = 8'd97;
  localparam logic [KEY_W-1:0] KEY_ALPHA_HI = 8'd122;
  localparam logic [BIN_W-1:0] ALPHA_BIN0   = 6'd10;

  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_PLACE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_LATE_CNT = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic             key_ok;
    logic [BIN_W-1:0] bin;
  } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fcsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcsi_front.sv =====
// Front end: accepts transactions, maps the key to a bin and queues the op
`timescale 1ns / 1ps
`default_nettype none

module fcsi_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   action,
  input  wire logic [7:0]   key,
  output logic              q_valid,
  output fcsi_pkg::op_t     q_data,
  input  wire logic         q_pop
);
  import fcsi_pkg::*;

  op_t              cls;
  logic [KEY_W-1:0] digit_off;
  logic [KEY_W-1:0] alpha_off;
  op_t              fifo [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign digit_off = key - KEY_DIGIT_LO;
  assign alpha_off = key - (KEY_ALPHA_LO - {2'b00, ALPHA_BIN0});

  always_comb begin
    cls.action = action;
    cls.key_ok = 1'b0;
    cls.bin    = '0;
    if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
      cls.key_ok = 1'b1;
      cls.bin    = digit_off[BIN_W-1:0];
    end else if (key >= KEY_ALPHA_LO && key <= KEY_ALPHA_HI) begin
      cls.key_ok = 1'b1;
      cls.bin    = alpha_off[BIN_W-1:0];
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcsi_back.sv =====
// Back end: bin table sequencer with prefix pass and result register
`timescale 1ns / 1ps
`default_nettype none

module fcsi_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire fcsi_pkg::op_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [19:0]        position,
  output logic [1:0]         status
);
  import fcsi_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_PFX_RD = 3'd2;
  localparam logic [2:0] S_PFX_WR = 3'd3;
  localparam logic [2:0] S_PFX_END = 3'd4;

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

  logic [2:0]       state;
  op_t              cur;
  logic             placing;
  logic [CNT_W-1:0] total;
  logic [BINS-1:0]  bin_vld;
  logic [BIN_W-1:0] pidx;
  logic [CNT_W-1:0] run;

  logic             rd_en;
  logic [BIN_W-1:0] rd_addr;
  logic [CNT_W-1:0] rd_data;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  logic [CNT_W-1:0] entry;
  logic             slot_free;
  logic             finish;
  logic [POS_W-1:0] res_pos;
  logic [1:0]       res_st;
  logic             bump;
  logic             bump_total;

  fcsi_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_free = !out_valid || out_ready;
  assign finish    = (state == S_EXEC) && slot_free;

  always_comb begin
    entry = '0;
    if (state == S_PFX_WR) begin
      entry = bin_vld[pidx] ? rd_data : '0;
    end else begin
      entry = bin_vld[cur.bin] ? rd_data : '0;
    end
  end

  always_comb begin
    res_pos    = '0;
    res_st     = ST_OK;
    bump       = 1'b0;
    bump_total = 1'b0;
    unique case (cur.action)
      ACT_COUNT: begin
        priority if (!cur.key_ok) begin
          res_st = ST_IGNORED;
        end else if (placing) begin
          res_st = ST_LATE_CNT;
        end else if (total >= MAX_ITEMS) begin
          res_st = ST_OVERFLOW;
        end else begin
          bump       = 1'b1;
          bump_total = 1'b1;
        end
      end
      ACT_PLACE: begin
        priority if (!cur.key_ok) begin
          res_st = ST_IGNORED;
        end else if (entry >= MAX_ITEMS) begin
          res_st = ST_OVERFLOW;
        end else begin
          res_pos = entry[POS_W-1:0];
          bump    = 1'b1;
        end
      end
      ACT_CLEAR: begin
        res_st = ST_OK;
      end
      default: begin
        res_st = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    q_pop   = (state == S_IDLE) && q_valid;
    rd_en   = 1'b0;
    rd_addr = cur.bin;
    wr_en   = 1'b0;
    wr_addr = cur.bin;
    wr_data = entry + CNT_W'(1);
    unique case (state)
      S_IDLE: begin
        rd_en   = q_valid;
        rd_addr = q_data.bin;
      end
      S_PFX_RD: begin
        rd_en   = 1'b1;
        rd_addr = pidx;
      end
      S_PFX_WR: begin
        wr_en   = 1'b1;
        wr_addr = pidx;
        wr_data = run;
      end
      S_PFX_END: begin
        rd_en = 1'b1;
      end
      S_EXEC: begin
        wr_en = finish && bump;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (finish) begin
      position <= res_pos;
      status   <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      placing   <= 1'b0;
      total     <= '0;
      bin_vld   <= '0;
      pidx      <= '0;
      run       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.action == ACT_PLACE && !placing) begin
              pidx  <= '0;
              run   <= '0;
              state <= S_PFX_RD;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_PFX_RD: begin
          state <= S_PFX_WR;
        end
        S_PFX_WR: begin
          bin_vld[pidx] <= 1'b1;
          run           <= run + entry;
          if (pidx == LAST_BIN) begin
            placing <= 1'b1;
            state   <= S_PFX_END;
          end else begin
            pidx  <= pidx + BIN_W'(1);
            state <= S_PFX_RD;
          end
        end
        S_PFX_END: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (finish) begin
            state <= S_IDLE;
            if (bump) begin
              bin_vld[cur.bin] <= 1'b1;
            end
            if (bump_total) begin
              total <= total + CNT_W'(1);
            end
            if (cur.action == ACT_CLEAR) begin
              bin_vld <= '0;
              placing <= 1'b0;
              total   <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/first_char_counting_sort_index.sv =====
// Top level of the first-character counting sort index engine
// An accepted transaction is queued in the front end; the back end then reads its bin,
// finishes any read-modify-write of the bin RAM and registers the result before taking
// the next one. The first place after counting adds a prefix pass over every bin.
// Reset: synchronous; per-bin valid flags make the whole table read as zero at once,
// so no clearing pass is needed and input is taken in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module first_char_counting_sort_index (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      position,
  output logic [1:0]       status
);
  import fcsi_pkg::*;

  logic q_valid;
  op_t  q_data;
  logic q_pop;

  fcsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .key      (key),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  fcsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .status    (status)
  );

endmodule

`default_nettype wire
